FILE: rtl/tps_pkg.sv
// Shared types, constants and helpers for the triangle plane slicer.
`timescale 1ns / 1ps
package tps_pkg;

	localparam int MAX_PLANES_DEF   = 1024;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam int MAG_W   = 33;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int IDX_W   = 10;

	// Configuration register indexes.
	localparam logic [1:0] REG_FIRST_PLANE_Z = 2'd0;
	localparam logic [1:0] REG_PLANE_PITCH   = 2'd1;
	localparam logic [1:0] REG_PLANE_COUNT   = 2'd2;

	// Coordinate selects.
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} tri_t;

	typedef struct packed {
		logic [9:0]         plane_index;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic               last;
		logic               truncated;
	} seg_t;

	// One cut request: p + (q - p) * num / den, rounded to nearest.
	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] q;
		logic [MAG_W-1:0]   num;
		logic [MAG_W-1:0]   den;
	} cut_req_t;

	function automatic logic signed [31:0] get_coord(tri_t t, logic [1:0] vtx,
			logic [1:0] ax);
		logic signed [31:0] r;
		r = t.a_x;
		unique case ({vtx, ax})
			{2'd0, AX_X}: r = t.a_x;
			{2'd0, AX_Y}: r = t.a_y;
			{2'd0, AX_Z}: r = t.a_z;
			{2'd1, AX_X}: r = t.b_x;
			{2'd1, AX_Y}: r = t.b_y;
			{2'd1, AX_Z}: r = t.b_z;
			{2'd2, AX_X}: r = t.c_x;
			{2'd2, AX_Y}: r = t.c_y;
			{2'd2, AX_Z}: r = t.c_z;
			default:      r = t.a_x;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next_vtx(logic [1:0] vtx);
		logic [1:0] r;
		unique case (vtx)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/tps_cut.sv
// Shared cut unit: multiply, bit-serial restoring divide and rounding.
`timescale 1ns / 1ps
module tps_cut import tps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cut_req_t           req,
	output logic               done,
	output logic signed [31:0] res
);

	typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_RND} cstate_t;

	cstate_t            state_q;
	cut_req_t           req_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MAG_W-1:0]   rem_q;
	logic [MAG_W-1:0]   quo_q;
	logic [6:0]         cnt_q;
	logic               done_q;
	logic signed [31:0] res_q;

	logic signed [32:0] delta;
	logic [MAG_W-1:0]   mag;
	logic [MAG_W:0]     rem_sh;
	logic               ge;
	logic [MAG_W:0]     off;
	logic signed [34:0] sum;

	always_comb begin
		delta  = 33'(req_q.q) - 33'(req_q.p);
		mag    = delta[32] ? MAG_W'(-delta) : MAG_W'(delta);
		rem_sh = {rem_q, prod_q[PROD_W-1]};
		ge     = rem_sh >= {1'b0, req_q.den};
		// Round half away from zero: bump when twice the remainder reaches den.
		off    = {1'b0, quo_q} + (MAG_W+1)'({rem_q, 1'b0} >= {1'b0, req_q.den});
		sum    = neg_q ? 35'(req_q.p) - 35'(off) : 35'(req_q.p) + 35'(off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					neg_q   <= delta[32];
					prod_q  <= PROD_W'(mag) * PROD_W'(req_q.num);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= 7'(PROD_W);
					state_q <= C_DIV;
				end
				C_DIV: begin
					rem_q  <= ge ? MAG_W'(rem_sh - {1'b0, req_q.den}) : rem_sh[MAG_W-1:0];
					quo_q  <= {quo_q[MAG_W-2:0], ge};
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					cnt_q  <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= C_RND;
					end
				end
				C_RND: begin
					res_q   <= sum[31:0];
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: rtl/triangle_plane_slicer.sv
// Top level of the triangle plane slicer: sequencer, registers and output stage.
`timescale 1ns / 1ps
// Usage: one triangle word enters on in_valid/in_ready; segments leave on
// out_valid/out_ready, one word each, the final one of a triangle marked by
// last, with truncated set there if segments past MAX_SEGMENTS were dropped.
// A triangle that cuts no plane gives no output word at all.
// Registers are written via cfg_wen/cfg_addr/cfg_wdata, by the user only while idle; the block does not enforce it.
// Flow: in_ready is high only between triangles. The start search steps one
// plane at a time through the planes at or below the lowest vertex, each
// visited plane is tested for a cut, and each segment takes six cuts in the
// shared cut unit (one quotient bit per cycle over a 66-bit product).
// A finished segment is held back one step so that last can be set; it moves
// to the output register when the next one is ready or the walk ends. If the
// receiver stalls, the sequencer waits with both words held.
// Reset clears all control state and loads the register defaults.
module triangle_plane_slicer import tps_pkg::*; #(
	parameter int MAX_PLANES   = MAX_PLANES_DEF,
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  tri_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output seg_t        out_data
);

	localparam int KW = $clog2(MAX_PLANES + 1);
	localparam int HW = KW + 33;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_WALK, S_EDGE, S_CSTART, S_CWAIT, S_PUSH, S_FINISH
	} state_t;

	state_t                state_q;
	logic signed [31:0]    first_z_q;
	logic [30:0]           pitch_q;
	logic [10:0]           count_cfg_q;
	tri_t                  tri_q;
	logic signed [31:0]    zmin_q;
	logic signed [31:0]    zmax_q;
	logic [KW-1:0]         n_q;
	logic [KW-1:0]         k_q;
	logic signed [HW-1:0]  h_q;
	logic [1:0]            cut_edge_q [2];
	logic                  csel_q;
	logic [1:0]            coord_q;
	logic signed [31:0]    cuts_q [2][3];
	logic [CW-1:0]         seg_cnt_q;
	logic                  dropped_q;
	seg_t                  pend_q;
	logic                  pend_v_q;
	seg_t                  out_q;
	logic                  out_valid_q;

	logic signed [31:0]    lo_ab, hi_ab, zmin_in, zmax_in;
	logic [KW-1:0]         n_in;
	logic signed [HW:0]    d_e [3];
	logic                  cut_f [3];
	logic [1:0]            ncut;
	logic [1:0]            e0, e1;
	logic [1:0]            cur_edge;
	logic signed [HW:0]    dp, dq;
	logic [HW:0]           ap, aq;
	logic [MAG_W:0]        den_w;
	cut_req_t              req;
	logic                  cut_start, cut_done;
	logic signed [31:0]    cut_res;
	seg_t                  new_seg;
	logic                  out_free;
	logic                  out_load;
	seg_t                  out_next;
	logic signed [HW-1:0]  h_up, h_dn;

	// Triangle z range and clamped plane count, taken at acceptance, and the plane heights one pitch up and down.
	always_comb begin
		lo_ab   = (in_data.a_z < in_data.b_z) ? in_data.a_z : in_data.b_z;
		hi_ab   = (in_data.a_z > in_data.b_z) ? in_data.a_z : in_data.b_z;
		zmin_in = (in_data.c_z < lo_ab) ? in_data.c_z : lo_ab;
		zmax_in = (in_data.c_z > hi_ab) ? in_data.c_z : hi_ab;
		n_in    = (32'(count_cfg_q) > 32'(MAX_PLANES)) ? KW'(MAX_PLANES) : KW'(count_cfg_q);
		h_up    = h_q + HW'(pitch_q);
		h_dn    = h_q - HW'(pitch_q);
	end

	// Plane distance of each vertex, the strict sign change along each edge, the number of cut edges and the first two.
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			d_e[e] = (HW+1)'(get_coord(tri_q, 2'(e), AX_Z)) - (HW+1)'(h_q);
		end
		for (int e = 0; e < 3; e++) begin
			cut_f[e] = (d_e[e] < 0 && d_e[(e + 1) % 3] > 0) ||
				(d_e[e] > 0 && d_e[(e + 1) % 3] < 0);
		end
		ncut = 2'(cut_f[0]) + 2'(cut_f[1]) + 2'(cut_f[2]);
		e0   = cut_f[0] ? 2'd0 : 2'd1;
		e1   = (cut_f[0] && cut_f[1]) ? 2'd1 : 2'd2;
	end

	// Operands of the current cut.
	always_comb begin
		cur_edge = cut_edge_q[csel_q];
		dp       = (HW+1)'(get_coord(tri_q, cur_edge, AX_Z)) - (HW+1)'(h_q);
		dq       = (HW+1)'(get_coord(tri_q, next_vtx(cur_edge), AX_Z)) - (HW+1)'(h_q);
		ap       = dp[HW] ? (HW+1)'(-dp) : (HW+1)'(dp);
		aq       = dq[HW] ? (HW+1)'(-dq) : (HW+1)'(dq);
		den_w    = (MAG_W+1)'(ap[MAG_W-1:0]) + (MAG_W+1)'(aq[MAG_W-1:0]);
		req.p    = get_coord(tri_q, cur_edge, coord_q);
		req.q    = get_coord(tri_q, next_vtx(cur_edge), coord_q);
		req.num  = ap[MAG_W-1:0];
		req.den  = den_w[MAG_W-1:0];
	end

	assign cut_start = (state_q == S_CSTART);

	tps_cut u_cut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cut_start),
		.req    (req),
		.done   (cut_done),
		.res    (cut_res)
	);

	always_comb begin
		new_seg.plane_index = IDX_W'(k_q);
		new_seg.start_x     = cuts_q[1][0];
		new_seg.start_y     = cuts_q[1][1];
		new_seg.start_z     = cuts_q[1][2];
		new_seg.end_x       = cuts_q[0][0];
		new_seg.end_y       = cuts_q[0][1];
		new_seg.end_z       = cuts_q[0][2];
		new_seg.last        = 1'b0;
		new_seg.truncated   = 1'b0;
		out_free            = !out_valid_q || out_ready;
		// The held word moves out on the next push or, marked as last, at the end.
		out_load            = pend_v_q && out_free &&
			(state_q == S_PUSH || state_q == S_FINISH);
		out_next            = pend_q;
		if (state_q == S_FINISH) begin
			out_next.last      = 1'b1;
			out_next.truncated = dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_z_q   <= '0;
			pitch_q     <= 31'd65536;
			count_cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_FIRST_PLANE_Z: first_z_q   <= cfg_wdata;
				REG_PLANE_PITCH:   pitch_q     <= cfg_wdata[30:0];
				REG_PLANE_COUNT:   count_cfg_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			seg_cnt_q   <= '0;
			dropped_q   <= 1'b0;
			csel_q      <= 1'b0;
			coord_q     <= '0;
		end else begin
			if (out_load) begin
				out_q       <= out_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tri_q     <= in_data;
						zmin_q    <= zmin_in;
						zmax_q    <= zmax_in;
						n_q       <= n_in;
						k_q       <= '0;
						h_q       <= HW'(first_z_q);
						seg_cnt_q <= '0;
						dropped_q <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (k_q < n_q && h_q <= HW'(zmin_q)) begin
						k_q <= k_q + KW'(1);
						h_q <= h_up;
					end else begin
						// Step back to the last plane at or below the lowest vertex, if any plane was passed.
						if (k_q != '0) begin
							k_q <= k_q - KW'(1);
							h_q <= h_dn;
						end
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (k_q < n_q && h_q <= HW'(zmax_q)) begin
						state_q <= S_EDGE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_EDGE: begin
					if (ncut == 2'd2) begin
						if (seg_cnt_q < CW'(MAX_SEGMENTS)) begin
							cut_edge_q[0] <= e0;
							cut_edge_q[1] <= e1;
							csel_q        <= 1'b0;
							coord_q       <= AX_X;
							state_q       <= S_CSTART;
						end else begin
							dropped_q <= 1'b1;
							state_q   <= S_FINISH;
						end
					end else begin
						k_q     <= k_q + KW'(1);
						h_q     <= h_up;
						state_q <= S_WALK;
					end
				end
				S_CSTART: begin
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					if (cut_done) begin
						cuts_q[csel_q][coord_q] <= cut_res;
						if (coord_q == AX_Z) begin
							coord_q <= AX_X;
							csel_q  <= 1'b1;
							state_q <= csel_q ? S_PUSH : S_CSTART;
						end else begin
							coord_q <= coord_q + 2'd1;
							state_q <= S_CSTART;
						end
					end
				end
				S_PUSH: begin
					if (!pend_v_q || out_free) begin
						pend_q    <= new_seg;
						pend_v_q  <= 1'b1;
						seg_cnt_q <= seg_cnt_q + CW'(1);
						k_q       <= k_q + KW'(1);
						h_q       <= h_up;
						state_q   <= S_WALK;
					end
				end
				S_FINISH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
